@@ rtl/dpb_pkg.sv @@
package dpb_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;
    localparam int QUEUE_DEPTH        = 2;

    localparam int DEPTH_W    = 24;
    localparam int Z_W        = 23;
    localparam int COORD_W    = 32;
    localparam int COLOR_W    = 8;
    localparam int INV_W      = 24;
    localparam int CENTER_W   = 16;
    localparam int IWIDTH_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PRESENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd6;

    // reset values
    localparam logic [INV_W-1:0]    RST_INV_FOCAL = 24'd16777;
    localparam logic [CENTER_W-1:0] RST_CENTER_X  = 16'd10240;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y  = 16'd7680;
    localparam logic [Z_W-1:0]      RST_MAX_DEPTH = 23'd6553600;
    localparam logic [IWIDTH_W-1:0] RST_IWIDTH    = 13'd1280;

    typedef struct packed {
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [Z_W-1:0]      max_depth;
        logic                color_present;
        logic [IWIDTH_W-1:0] image_width;
    } t_cfg;

endpackage

@@ rtl/dpb_fifo.sv @@
module dpb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = dpb_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_rd) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/dpb_front.sv @@
module dpb_front #(
    parameter int MAX_WIDTH  = dpb_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = dpb_pkg::DEFAULT_MAX_HEIGHT,
    parameter int MAG_W      = 16,
    parameter int ITEM_W     = 2 * (MAG_W + 1) + dpb_pkg::Z_W + 3 * dpb_pkg::COLOR_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dpb_pkg::t_cfg                  i_cfg,
    input  logic                           i_accept,
    input  logic [dpb_pkg::DEPTH_W-1:0]    i_depth,
    input  logic [dpb_pkg::COLOR_W-1:0]    i_blue,
    input  logic [dpb_pkg::COLOR_W-1:0]    i_green,
    input  logic [dpb_pkg::COLOR_W-1:0]    i_red,
    input  logic                           i_frame_end,
    output logic                           o_push,
    output logic [ITEM_W-1:0]              o_item
);
    import dpb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCW = (CW + 1 > IWIDTH_W) ? CW + 1 : IWIDTH_W;
    localparam int DW  = MAG_W + 1;

    logic [CW-1:0]        r_col, n_col;
    logic [RW-1:0]        r_row, n_row;
    logic [WCW-1:0]       w_iw, w_eff;
    logic                 w_wrap;
    logic                 w_zok;
    logic [DW-1:0]        w_dx, w_dy;
    logic [MAG_W-1:0]     w_mx, w_my;
    logic [COLOR_W-1:0]   w_r, w_g, w_b;

    // effective row length: zero acts as one, clamp at MAX_WIDTH
    always_comb begin
        w_iw = WCW'(i_cfg.image_width);
        if (w_iw == '0) begin
            w_eff = WCW'(1);
        end else if (w_iw > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_iw;
        end
    end

    assign w_wrap = (WCW'(r_col) + WCW'(1) >= w_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (w_wrap) begin
            n_col = '0;
            if ((RW + 1)'(r_row) + (RW + 1)'(1) < (RW + 1)'(MAX_HEIGHT)) begin
                n_row = r_row + RW'(1);
            end
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Z must be in (0, max_depth]
    assign w_zok = !i_depth[DEPTH_W-1] && (i_depth != '0)
                && (i_depth[Z_W-1:0] <= i_cfg.max_depth);

    // Q.4 offsets from the principal point, split into sign and magnitude
    assign w_dx = DW'({r_col, 4'b0000}) - DW'(i_cfg.center_x);
    assign w_dy = DW'({r_row, 4'b0000}) - DW'(i_cfg.center_y);
    assign w_mx = w_dx[DW-1] ? MAG_W'(-w_dx) : w_dx[MAG_W-1:0];
    assign w_my = w_dy[DW-1] ? MAG_W'(-w_dy) : w_dy[MAG_W-1:0];

    assign w_r = i_cfg.color_present ? i_red   : '0;
    assign w_g = i_cfg.color_present ? i_green : '0;
    assign w_b = i_cfg.color_present ? i_blue  : '0;

    assign o_push = i_accept && w_zok;
    assign o_item = {w_dx[DW-1], w_mx, w_dy[DW-1], w_my, i_depth[Z_W-1:0], w_r, w_g, w_b};

endmodule

@@ rtl/dpb_back.sv @@
module dpb_back #(
    parameter int MAG_W  = 16,
    parameter int ITEM_W = 2 * (MAG_W + 1) + dpb_pkg::Z_W + 3 * dpb_pkg::COLOR_W,
    parameter int PT_W   = 2 * dpb_pkg::COORD_W + dpb_pkg::Z_W + 3 * dpb_pkg::COLOR_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpb_pkg::t_cfg     i_cfg,
    input  logic              i_q_empty,
    input  logic [ITEM_W-1:0] i_q_item,
    output logic              o_q_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output logic [PT_W-1:0]   o_out_point
);
    import dpb_pkg::*;

    localparam int P1W = MAG_W + Z_W;     // |offset| * Z
    localparam int AW  = P1W + 12;        // times one 12-bit half of the reciprocal
    localparam int SW  = AW + 1;
    localparam int QW  = SW - 16;         // rounded Q.16 magnitude
    localparam int RGB_W = 3 * COLOR_W;
    localparam logic [AW-1:0] RND = AW'(1) << 27;

    function automatic logic [COORD_W-1:0] sat(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        begin
            lim = neg ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
            if (q > lim) begin
                sat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                sat = neg ? COORD_W'(QW'(0) - q) : q[COORD_W-1:0];
            end
        end
    endfunction

    logic              w_en;
    logic              w_nx, w_ny;
    logic [MAG_W-1:0]  w_mx, w_my;
    logic [Z_W-1:0]    w_z;
    logic [RGB_W-1:0]  w_rgb;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              r1_nx, r1_ny, r2_nx, r2_ny, r3_nx, r3_ny;
    logic [Z_W-1:0]    r1_z, r2_z, r3_z, r4_z;
    logic [RGB_W-1:0]  r1_rgb, r2_rgb, r3_rgb, r4_rgb;
    logic [P1W-1:0]    r1_px, r1_py;
    logic [AW-1:0]     r2_ax, r2_bx, r2_ay, r2_by;
    logic [QW-1:0]     r3_qx, r3_qy;
    logic [COORD_W-1:0] r4_x, r4_y;

    assign {w_nx, w_mx, w_ny, w_my, w_z, w_rgb} = i_q_item;

    // whole pipe holds only when its last beat cannot leave
    assign w_en    = !(r_v4 && i_out_full);
    assign o_q_pop = w_en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: offset magnitude times depth
            r1_px  <= P1W'(w_mx) * P1W'(w_z);
            r1_py  <= P1W'(w_my) * P1W'(w_z);
            r1_nx  <= w_nx;
            r1_ny  <= w_ny;
            r1_z   <= w_z;
            r1_rgb <= w_rgb;
            // stage 2: partial products against high and low reciprocal halves
            r2_ax  <= AW'(r1_px) * AW'(i_cfg.inv_focal_x[INV_W-1:12]);
            r2_bx  <= AW'(r1_px) * AW'(i_cfg.inv_focal_x[11:0]) + RND;
            r2_ay  <= AW'(r1_py) * AW'(i_cfg.inv_focal_y[INV_W-1:12]);
            r2_by  <= AW'(r1_py) * AW'(i_cfg.inv_focal_y[11:0]) + RND;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_z   <= r1_z;
            r2_rgb <= r1_rgb;
            // stage 3: merge and round to Q.16
            r3_qx  <= QW'((SW'(r2_ax) + SW'(r2_bx >> 12)) >> 16);
            r3_qy  <= QW'((SW'(r2_ay) + SW'(r2_by >> 12)) >> 16);
            r3_nx  <= r2_nx;
            r3_ny  <= r2_ny;
            r3_z   <= r2_z;
            r3_rgb <= r2_rgb;
            // stage 4: sign and saturate
            r4_x   <= sat(r3_nx, r3_qx);
            r4_y   <= sat(r3_ny, r3_qy);
            r4_z   <= r3_z;
            r4_rgb <= r3_rgb;
        end
    end

    assign o_out_push  = r_v4 && !i_out_full;
    assign o_out_point = {r4_x, r4_y, r4_z, r4_rgb};

endmodule

@@ rtl/depth_to_point_backprojection_unit.sv @@
// Pinhole back-projection of a raster depth stream. Each beat pushed is one
// depth pixel (with its colour); column and row come from internal counters
// that wrap at image_width and clear after a frame_end beat. Pixels with depth
// not above zero or above max_depth advance the counters but give no point.
// Valid pixels give X=(u-cx)*Z*inv_fx, Y=(v-cy)*Z*inv_fy in Q15.16, rounded
// to nearest (ties away from zero) and saturated, plus Z and colour (zero when
// color_present is clear). Throughput is one pixel per clock while the result
// side keeps popping: the front counts and classifies in the accept cycle,
// a two-beat queue decouples it from a four-stage multiply pipeline (offset
// times Z, then two 12-bit halves of the reciprocal, merge/round, saturate),
// which feeds a two-beat result queue. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
module depth_to_point_backprojection_unit #(
    parameter int MAX_WIDTH  = dpb_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = dpb_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel side
    input  logic                              push,
    output logic                              full,
    input  logic [dpb_pkg::DEPTH_W-1:0]       i_depth,
    input  logic [dpb_pkg::COLOR_W-1:0]       i_blue,
    input  logic [dpb_pkg::COLOR_W-1:0]       i_green,
    input  logic [dpb_pkg::COLOR_W-1:0]       i_red,
    input  logic                              i_frame_end,
    // point side
    output logic                              empty,
    input  logic                              pop,
    output logic [dpb_pkg::COORD_W-1:0]       o_point_x,
    output logic [dpb_pkg::COORD_W-1:0]       o_point_y,
    output logic [dpb_pkg::Z_W-1:0]           o_point_z,
    output logic [dpb_pkg::COLOR_W-1:0]       o_out_red,
    output logic [dpb_pkg::COLOR_W-1:0]       o_out_green,
    output logic [dpb_pkg::COLOR_W-1:0]       o_out_blue
);
    import dpb_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CRW    = (CW > RW) ? CW : RW;
    // offset magnitude: u*16, v*16 or the 16-bit center, whichever is wider
    localparam int MAG_W  = (CRW + 4 > CENTER_W) ? CRW + 4 : CENTER_W;
    localparam int ITEM_W = 2 * (MAG_W + 1) + Z_W + 3 * COLOR_W;
    localparam int PT_W   = 2 * COORD_W + Z_W + 3 * COLOR_W;

    t_cfg              r_cfg;
    logic              w_accept;
    logic              w_mid_push, w_mid_full, w_mid_pop, w_mid_empty;
    logic [ITEM_W-1:0] w_mid_in, w_mid_out;
    logic              w_out_push, w_out_full;
    logic [PT_W-1:0]   w_out_in, w_out_data;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_focal_x   <= RST_INV_FOCAL;
            r_cfg.inv_focal_y   <= RST_INV_FOCAL;
            r_cfg.center_x      <= RST_CENTER_X;
            r_cfg.center_y      <= RST_CENTER_Y;
            r_cfg.max_depth     <= RST_MAX_DEPTH;
            r_cfg.color_present <= 1'b0;
            r_cfg.image_width   <= RST_IWIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INV_FOCAL_X:   r_cfg.inv_focal_x   <= i_cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:   r_cfg.inv_focal_y   <= i_cfg_data[INV_W-1:0];
                REG_CENTER_X:      r_cfg.center_x      <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:      r_cfg.center_y      <= i_cfg_data[CENTER_W-1:0];
                REG_MAX_DEPTH:     r_cfg.max_depth     <= i_cfg_data[Z_W-1:0];
                REG_COLOR_PRESENT: r_cfg.color_present <= i_cfg_data[0];
                REG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[IWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // a pixel is taken whenever the mid queue has room, even if it is rejected
    assign full     = w_mid_full;
    assign w_accept = push && !w_mid_full;

    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAG_W      (MAG_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_depth     (i_depth),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_frame_end (i_frame_end),
        .o_push      (w_mid_push),
        .o_item      (w_mid_in)
    );

    dpb_fifo #(
        .W     (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    dpb_back #(
        .MAG_W  (MAG_W),
        .ITEM_W (ITEM_W),
        .PT_W   (PT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_mid_empty),
        .i_q_item    (w_mid_out),
        .o_q_pop     (w_mid_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out_point (w_out_in)
    );

    dpb_fifo #(
        .W     (PT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty)
    );

    assign {o_point_x, o_point_y, o_point_z, o_out_red, o_out_green, o_out_blue} = w_out_data;

    // front never pushes into a full mid queue
    a_mid_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_push |-> !w_mid_full)
        else $error("mid queue overflow");

    // a non-positive depth never makes a point
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_depth[DEPTH_W-1] || i_depth == '0)) |-> !w_mid_push)
        else $error("rejected depth pushed");

    // every delivered point has a positive Z
    a_z_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_point_z != '0))
        else $error("point with zero depth");

    // colour forced to zero when no colour input
    a_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !r_cfg.color_present) |->
            (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0))
        else $error("colour leaked without color_present");

endmodule

@@ sim/tb_depth_to_point_backprojection_unit.sv @@
`timescale 1ns / 1ps

module tb_depth_to_point_backprojection_unit;
    import dpb_pkg::*;

    localparam int MAX_W         = DEFAULT_MAX_WIDTH;
    localparam int MAX_H         = DEFAULT_MAX_HEIGHT;
    localparam int SETTLE_CYCLES = 20;    // well past the push-to-point latency
    localparam int STALL_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES   = 300;   // long sink back-pressure stretch
    localparam int PHASE_PIXELS  = 80;

    // index past the end of the register map, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               frame_end;
        int                 gap;
    } t_pixel;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [Z_W-1:0]     z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_point;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [DEPTH_W-1:0]    i_depth     = '0;
    logic [COLOR_W-1:0]    i_blue      = '0;
    logic [COLOR_W-1:0]    i_green     = '0;
    logic [COLOR_W-1:0]    i_red       = '0;
    logic                  i_frame_end = 1'b0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [COORD_W-1:0]    o_point_x;
    logic [COORD_W-1:0]    o_point_y;
    logic [Z_W-1:0]        o_point_z;
    logic [COLOR_W-1:0]    o_out_red;
    logic [COLOR_W-1:0]    o_out_green;
    logic [COLOR_W-1:0]    o_out_blue;

    depth_to_point_backprojection_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_depth     (i_depth),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_frame_end (i_frame_end),
        .empty       (empty),
        .pop         (pop),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Camera model: its own copy of the registers and raster counters
    // ------------------------------------------------------------------
    t_cfg cam_cfg = '{
        inv_focal_x:   RST_INV_FOCAL,
        inv_focal_y:   RST_INV_FOCAL,
        center_x:      RST_CENTER_X,
        center_y:      RST_CENTER_Y,
        max_depth:     RST_MAX_DEPTH,
        color_present: 1'b0,
        image_width:   RST_IWIDTH
    };
    int col_cnt = 0;
    int row_cnt = 0;

    t_pixel pending_pix[$];    // pixels not yet offered to the block
    t_point expected_pts[$];   // points predicted but not yet popped

    // stimulus knobs, owned by the stimulus initial block
    bit src_idle      = 1'b0;
    bit sink_idle     = 1'b0;
    bit sink_hold_req = 1'b0;

    // beat flags, registered at the rising edge for the falling-edge drivers
    logic pix_beat = 1'b0;
    logic pt_beat  = 1'b0;

    int mismatch_cnt = 0;
    int pts_seen     = 0;

    // |offset| (Q.4) * Z (Q.16) * reciprocal (Q0.24) is exact Q.44; round to Q.16
    // with ties away from zero, then sign and clamp to 32 bits.
    function automatic logic [COORD_W-1:0] project_axis(input int off,
                                                        input logic [Z_W-1:0] z,
                                                        input logic [INV_W-1:0] inv);
        logic [79:0]        prod;
        logic [79:0]        q;
        logic [COORD_W-1:0] m;
        int unsigned        mag;
        mag  = (off < 0) ? -off : off;
        prod = 80'(mag) * 80'(z) * 80'(inv) + (80'd1 << 27);
        q    = prod >> 28;
        if (off >= 0)
            return (q > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        m = (q > 80'h8000_0000) ? 32'h8000_0000 : q[31:0];
        return 32'd0 - m;
    endfunction

    // one accepted pixel: maybe a point, then advance the raster position
    task automatic model_pixel(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] b,
                               input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r,
                               input logic fe);
        int     z;
        int     eff_w;
        t_point pt;
        z = int'($signed(d));
        if (z > 0 && z <= int'(cam_cfg.max_depth)) begin
            pt.x     = project_axis(col_cnt * 16 - int'(cam_cfg.center_x), d[Z_W-1:0],
                                    cam_cfg.inv_focal_x);
            pt.y     = project_axis(row_cnt * 16 - int'(cam_cfg.center_y), d[Z_W-1:0],
                                    cam_cfg.inv_focal_y);
            pt.z     = d[Z_W-1:0];
            pt.red   = cam_cfg.color_present ? r : '0;
            pt.green = cam_cfg.color_present ? g : '0;
            pt.blue  = cam_cfg.color_present ? b : '0;
            expected_pts = {expected_pts, pt};
        end
        // zero width behaves as one, oversize clamps to the counter range
        eff_w = int'(cam_cfg.image_width);
        if (eff_w == 0) eff_w = 1;
        if (eff_w > MAX_W) eff_w = MAX_W;
        if (fe) begin
            col_cnt = 0;
            row_cnt = 0;
        end else if (col_cnt + 1 >= eff_w) begin
            col_cnt = 0;
            if (row_cnt + 1 < MAX_H) row_cnt++;    // row sticks at the last line
        end else begin
            col_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: rising edge, predicts on pixel beats, checks on point beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        pix_beat <= i_rst_n && push && !full;
        pt_beat  <= i_rst_n && pop && !empty;
        if (i_rst_n) begin
            if (push && !full)
                model_pixel(i_depth, i_blue, i_green, i_red, i_frame_end);
            if (pop && !empty) begin
                got = '{o_point_x, o_point_y, o_point_z, o_out_red, o_out_green, o_out_blue};
                if (expected_pts.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("point %0d: none expected, got x=%h y=%h z=%h rgb=%h/%h/%h",
                                 pts_seen, got.x, got.y, got.z, got.red, got.green, got.blue);
                    mismatch_cnt++;
                end else begin
                    want = expected_pts.pop_front();
                    if (got !== want) begin
                        if (mismatch_cnt < 10)
                            $display({"point %0d: exp x=%h y=%h z=%h rgb=%h/%h/%h, ",
                                      "got x=%h y=%h z=%h rgb=%h/%h/%h"},
                                     pts_seen, want.x, want.y, want.z,
                                     want.red, want.green, want.blue,
                                     got.x, got.y, got.z, got.red, got.green, got.blue);
                        mismatch_cnt++;
                    end
                end
                pts_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: falling edge, one pixel held on the ports until its beat
    // ------------------------------------------------------------------
    bit     src_busy = 1'b0;
    int     src_wait = 0;
    t_pixel src_pix;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pix_beat) src_busy = 1'b0;
            if (!src_busy && pending_pix.size() > 0) begin
                if (src_wait < pending_pix[0].gap) begin
                    src_wait++;
                end else begin
                    src_pix     = pending_pix.pop_front();
                    i_depth     <= src_pix.depth;
                    i_blue      <= src_pix.blue;
                    i_green     <= src_pix.green;
                    i_red       <= src_pix.red;
                    i_frame_end <= src_pix.frame_end;
                    src_busy    = 1'b1;
                    src_wait    = 0;
                end
            end
            push <= src_busy;
        end
    end

    // ------------------------------------------------------------------
    // Point sink: falling edge, random wait per point plus one long hold
    // ------------------------------------------------------------------
    int sink_wait  = 0;
    int hold_cnt   = 0;
    bit hold_taken = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pt_beat) sink_wait = sink_idle ? $urandom_range(0, 18) : 0;
            if (sink_hold_req && !hold_taken) begin
                hold_cnt   = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles in a row with neither a pixel nor a point beat
    // ------------------------------------------------------------------
    int stall_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("** depth_to_point_backprojection_unit: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_pix(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] r,
                           input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b,
                           input logic fe);
        t_pixel p;
        p.depth     = d;
        p.red       = r;
        p.green     = g;
        p.blue      = b;
        p.frame_end = fe;
        p.gap       = src_idle ? $urandom_range(0, 18) : 0;
        pending_pix = {pending_pix, p};
    endtask

    // mostly in-range depths, the rest zero, negative, too far or the extremes
    function automatic logic [DEPTH_W-1:0] pick_depth();
        logic [Z_W-1:0] lim;
        lim = cam_cfg.max_depth;
        case ($urandom_range(0, 9))
            0: return DEPTH_W'(lim) + DEPTH_W'($urandom_range(1, 1 << 16));
            1: return 24'h80_0000 | DEPTH_W'($urandom());
            2: return $urandom_range(0, 1) ? 24'h00_0000 : 24'h7F_FFFF;
            default: return (lim == 0) ? DEPTH_W'($urandom())
                                       : DEPTH_W'($urandom_range(1, lim));
        endcase
    endfunction

    // wait out every queued pixel and every predicted point, then let the
    // pipeline flush anything that makes no point
    task automatic drain();
        while (pending_pix.size() != 0 || src_busy) @(posedge i_clk);
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_INV_FOCAL_X:   cam_cfg.inv_focal_x   = val[INV_W-1:0];
            REG_INV_FOCAL_Y:   cam_cfg.inv_focal_y   = val[INV_W-1:0];
            REG_CENTER_X:      cam_cfg.center_x      = val[CENTER_W-1:0];
            REG_CENTER_Y:      cam_cfg.center_y      = val[CENTER_W-1:0];
            REG_MAX_DEPTH:     cam_cfg.max_depth     = val[Z_W-1:0];
            REG_COLOR_PRESENT: cam_cfg.color_present = val[0];
            REG_IMAGE_WIDTH:   cam_cfg.image_width   = val[IWIDTH_W-1:0];
            default: ;
        endcase
    endtask

    // full register set, then a stray write past the map that must not land
    task automatic set_camera(input logic [INV_W-1:0] ifx, input logic [INV_W-1:0] ify,
                              input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                              input logic [Z_W-1:0] maxd, input logic color,
                              input logic [IWIDTH_W-1:0] w);
        cfg_write(REG_INV_FOCAL_X, CFG_DATA_W'(ifx));
        cfg_write(REG_INV_FOCAL_Y, CFG_DATA_W'(ify));
        cfg_write(REG_CENTER_X, CFG_DATA_W'(cx));
        cfg_write(REG_CENTER_Y, CFG_DATA_W'(cy));
        cfg_write(REG_MAX_DEPTH, CFG_DATA_W'(maxd));
        cfg_write(REG_COLOR_PRESENT, CFG_DATA_W'(color));
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(REG_SPARE, CFG_DATA_W'($urandom()));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Reset, directed pixels, random phases, end of run
    // ------------------------------------------------------------------
    initial begin
        logic [IWIDTH_W-1:0] w;
        logic [INV_W-1:0]    ifx;
        logic [INV_W-1:0]    ify;
        logic [Z_W-1:0]      maxd;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: depth limits and sign, color masked off
        add_pix(24'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pix(24'd0, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pix(24'hFF_FFFF, 8'hA5, 8'h5A, 8'hC3, 1'b0);
        add_pix(24'h80_0000, 8'hFF, 8'h00, 8'hFF, 1'b0);
        add_pix(24'h7F_FFFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        add_pix(DEPTH_W'(RST_MAX_DEPTH), 8'h12, 8'h34, 8'h56, 1'b0);
        add_pix(DEPTH_W'(RST_MAX_DEPTH) + 24'd1, 8'h12, 8'h34, 8'h56, 1'b0);
        add_pix(24'h01_8000, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pix(24'h02_0000, 8'h01, 8'h02, 8'h03, 1'b0);
        drain();

        // saturation: full-scale reciprocals, extreme centers, max depth,
        // width 3 so rows wrap; color on
        set_camera(24'hFF_FFFF, 24'hFF_FFFF, 16'h0000, 16'hFFFF, 23'h7F_FFFF, 1'b1, 13'd3);
        add_pix(24'h7F_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pix(24'h7F_FFFF, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pix(24'h7F_FFFF, 8'hAA, 8'h55, 8'hF0, 1'b0);
        add_pix(24'h00_0001, 8'h0F, 8'hF0, 8'h3C, 1'b0);
        add_pix(24'h7F_FFFF, 8'hFF, 8'h00, 8'h80, 1'b1);
        add_pix(24'h40_0000, 8'h80, 8'h7F, 8'h01, 1'b0);
        add_pix(24'h00_0000, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pix(24'h7F_FFFF, 8'h11, 8'h22, 8'h33, 1'b0);
        drain();

        // zero depth limit: nothing may come out; zero width counts as one
        set_camera(24'd16777, 24'd16777, 16'd100, 16'd100, 23'd0, 1'b1, 13'd0);
        add_pix(24'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pix(24'h7F_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pix(24'h40_0000, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pix(24'h00_0000, 8'h00, 8'h00, 8'h00, 1'b1);

        // random phases, each with its own camera
        for (int k = 0; k < 6; k++) begin
            drain();
            case (k)
                0: w = 13'd0;
                1: w = 13'h1FFF;     // oversize, clamps to the maximum
                2: w = 13'd4096;
                3: w = 13'd1;
                4: w = 13'($urandom_range(2, 4096));
                default: w = 13'($urandom_range(2, 24));
            endcase
            ifx  = $urandom_range(0, 1) ? INV_W'($urandom()) : INV_W'($urandom_range(4000, 70000));
            ify  = $urandom_range(0, 1) ? INV_W'($urandom()) : INV_W'($urandom_range(4000, 70000));
            maxd = Z_W'($urandom_range(1 << 16, 23'h7F_FFFF));
            if (k == 3) begin
                ifx = '0;
                ify = '0;
            end
            if (k == 2) begin
                ifx  = 24'hFF_FFFF;
                ify  = 24'hFF_FFFF;
                maxd = 23'h7F_FFFF;
            end
            set_camera(ifx, ify,
                       $urandom_range(0, 1) ? CENTER_W'($urandom()) : CENTER_W'($urandom_range(0, 400)),
                       $urandom_range(0, 1) ? CENTER_W'($urandom()) : CENTER_W'($urandom_range(0, 400)),
                       maxd, k[0], w);
            // phase 1: sender runs flat out while the sink holds off, so the
            // block fills and drops its input ready
            src_idle  = (k != 1) && ($urandom_range(0, 3) != 0);
            sink_idle = $urandom_range(0, 3) != 0;
            if (k == 1) sink_hold_req = 1'b1;
            for (int n = 0; n < PHASE_PIXELS; n++)
                add_pix(pick_depth(), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                        $urandom_range(0, 31) == 0);
        end
        drain();

        if (mismatch_cnt == 0 && expected_pts.size() == 0)
            $display("** depth_to_point_backprojection_unit: PASSED **");
        else
            $display("** depth_to_point_backprojection_unit: FAILED **");
        $finish;
    end

endmodule
